// ===== hw/rtl/sfsm_pkg.sv =====
`timescale 1ns / 1ps
package sfsm_pkg;

	localparam int FRAME_LENGTH = 2048;
	localparam int CNT_W        = $clog2(FRAME_LENGTH);
	localparam int UPPER_START  = FRAME_LENGTH - FRAME_LENGTH / 2;
	localparam int PASS_LAST    = 21;

	localparam int DATA_W = 24;
	localparam int NUM_W  = 11;
	localparam int HIST   = 20;
	localparam int NCOEF  = 11;
	localparam int COEF_W = 16;
	localparam int PRE_W  = DATA_W + 1;
	localparam int PROD_W = 42;
	localparam int ACC_W  = 44;
	localparam int FRAC_W = 18;

	localparam logic signed [DATA_W-1:0] S24_MAX = 24'sh7FFFFF;
	localparam logic signed [DATA_W-1:0] S24_MIN = 24'sh800000;

	localparam logic [COEF_W-1:0] COEF [NCOEF] = '{
		16'd2, 16'd62, 16'd387, 16'd1395, 16'd3697, 16'd7859,
		16'd14025, 16'd21574, 16'd29070, 16'd34645, 16'd36712
	};

	typedef struct packed {
		logic signed [DATA_W-1:0] raw;
		logic [NUM_W-1:0]         num;
		logic                     pass;
		logic                     upper;
		logic                     last;
	} sb_t;

endpackage

// ===== hw/rtl/sfsm_fir.sv =====
`timescale 1ns / 1ps
module sfsm_fir import sfsm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] bin_value,
	output logic                     acc_valid,
	input  logic                     acc_ready,
	output logic signed [ACC_W-1:0]  acc,
	output sb_t                      acc_sb
);

	logic signed [DATA_W-1:0] dly_q [HIST];
	logic [CNT_W-1:0]         cnt_q;

	logic v1, v2, v3, v4;
	logic en1, en2, en3, en4;

	logic signed [PRE_W-1:0]  pre_s1  [NCOEF];
	logic signed [PROD_W-1:0] prod_s2 [NCOEF];
	logic signed [ACC_W-1:0]  part_s3 [3];
	logic signed [ACC_W-1:0]  acc_s4;
	sb_t sb_s1, sb_s2, sb_s3, sb_s4;

	logic signed [PRE_W-1:0]  pre_c  [NCOEF];
	logic signed [PROD_W-1:0] prod_c [NCOEF];
	logic [31:0]              cnt_ext;
	sb_t                      sb_c;
	logic                     in_xfer;

	assign en4 = !v4 || acc_ready;
	assign en3 = !v3 || en4;
	assign en2 = !v2 || en3;
	assign en1 = !v1 || en2;
	assign in_ready = en1;
	assign in_xfer = in_valid && en1;

	always_comb begin
		pre_c[0] = PRE_W'(bin_value) + PRE_W'(dly_q[HIST-1]);
		for (int m = 1; m < NCOEF - 1; m++) begin
			pre_c[m] = PRE_W'(dly_q[m-1]) + PRE_W'(dly_q[HIST-1-m]);
		end
		pre_c[NCOEF-1] = PRE_W'(dly_q[NCOEF-2]);
		cnt_ext   = 32'(cnt_q);
		sb_c.raw  = bin_value;
		sb_c.num  = cnt_ext[NUM_W-1:0];
		sb_c.pass = cnt_q <= CNT_W'(PASS_LAST);
		sb_c.upper = cnt_q >= CNT_W'(UPPER_START);
		sb_c.last = cnt_q == CNT_W'(FRAME_LENGTH - 1);
	end

	always_comb begin
		for (int m = 0; m < NCOEF; m++) begin
			prod_c[m] = PROD_W'(pre_s1[m]) * PROD_W'($signed({1'b0, COEF[m]}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HIST; k++) dly_q[k] <= '0;
			cnt_q <= '0;
		end else if (in_xfer) begin
			dly_q[0] <= bin_value;
			for (int k = 1; k < HIST; k++) dly_q[k] <= dly_q[k-1];
			cnt_q <= sb_c.last ? '0 : cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
		end else begin
			if (en1) v1 <= in_valid;
			if (en2) v2 <= v1;
			if (en3) v3 <= v2;
			if (en4) v4 <= v3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pre_s1 <= pre_c;
			sb_s1  <= sb_c;
		end
		if (en2) begin
			prod_s2 <= prod_c;
			sb_s2   <= sb_s1;
		end
		if (en3) begin
			part_s3[0] <= ACC_W'(prod_s2[0]) + ACC_W'(prod_s2[1])
				+ ACC_W'(prod_s2[2]) + ACC_W'(prod_s2[3]);
			part_s3[1] <= ACC_W'(prod_s2[4]) + ACC_W'(prod_s2[5])
				+ ACC_W'(prod_s2[6]) + ACC_W'(prod_s2[7]);
			part_s3[2] <= ACC_W'(prod_s2[8]) + ACC_W'(prod_s2[9])
				+ ACC_W'(prod_s2[10]) + (ACC_W'(1) <<< (FRAC_W - 1));
			sb_s3 <= sb_s2;
		end
		if (en4) begin
			acc_s4 <= part_s3[0] + part_s3[1] + part_s3[2];
			sb_s4  <= sb_s3;
		end
	end

	assign acc_valid = v4;
	assign acc       = acc_s4;
	assign acc_sb    = sb_s4;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FRAME_LENGTH - 1))
		else $error("bin counter out of range");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !sb_c.last |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("bin counter did not advance on transfer");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v4 && !acc_ready |=> v4 && $stable(acc_s4))
		else $error("accumulator stage lost data under stall");

endmodule

// ===== hw/rtl/sfsm_track.sv =====
`timescale 1ns / 1ps
module sfsm_track import sfsm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     acc_valid,
	output logic                     acc_ready,
	input  logic signed [ACC_W-1:0]  acc,
	input  sb_t                      acc_sb,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] smoothed_value,
	output logic [NUM_W-1:0]         bin_number,
	output logic                     frame_done,
	output logic signed [DATA_W-1:0] upper_min,
	output logic signed [DATA_W-1:0] upper_max
);

	logic signed [DATA_W-1:0] min_q, max_q;
	logic signed [ACC_W-1:0]  shifted;
	logic signed [DATA_W-1:0] sat, y, new_min, new_max;
	logic                     en, load;

	assign en        = !out_valid || out_ready;
	assign acc_ready = en;
	assign load      = en && acc_valid;

	always_comb begin
		shifted = acc >>> FRAC_W;
		if (shifted > ACC_W'(S24_MAX))      sat = S24_MAX;
		else if (shifted < ACC_W'(S24_MIN)) sat = S24_MIN;
		else                                sat = shifted[DATA_W-1:0];
		y       = acc_sb.pass ? acc_sb.raw : sat;
		new_min = (acc_sb.upper && y < min_q) ? y : min_q;
		new_max = (acc_sb.upper && y > max_q) ? y : max_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			min_q     <= S24_MAX;
			max_q     <= S24_MIN;
		end else begin
			if (en) out_valid <= acc_valid;
			if (load) begin
				min_q <= acc_sb.last ? S24_MAX : new_min;
				max_q <= acc_sb.last ? S24_MIN : new_max;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			smoothed_value <= y;
			bin_number     <= acc_sb.num;
			frame_done     <= acc_sb.last;
			upper_min      <= acc_sb.last ? new_min : '0;
			upper_max      <= acc_sb.last ? new_max : '0;
		end
	end

	a_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_done |-> upper_min == '0 && upper_max == '0)
		else $error("min/max reported off frame end");

	a_report_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> upper_min <= upper_max)
		else $error("upper min above upper max");

	a_track_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		load && acc_sb.last |=> min_q == S24_MAX && max_q == S24_MIN)
		else $error("trackers not rearmed after frame end");

endmodule

// ===== hw/rtl/spectrum_fir_smoother_minmax.sv =====
`timescale 1ns / 1ps
// Spectrum smoother: 21-tap symmetric low-pass FIR over a stream of spectrum
// bins, plus min/max tracking over the upper half of each frame.
// Input channel: in_valid/in_ready with bin_value (signed Q15.8), one bin per
// transfer, bins of a frame in ascending order, FRAME_LENGTH bins per frame.
// Output channel: out_valid/out_ready with smoothed_value, bin_number,
// frame_done and, on the last bin of a frame, upper_min/upper_max (zero
// otherwise). Bins 0..21 of each frame pass through unchanged.
// From input transfer to out_valid a bin passes through pre-add, constant
// multiply, partial sums and final sum, then round/saturate/track into the
// output register. Throughput: one bin per cycle while out_ready stays high,
// set by the five-deep register pipeline with independent stage valids.
// Stall: when out_ready is low, the held result stays put and earlier stages
// keep filling until the pipeline is full; then in_ready drops.
// Reset (arst_n low): pipeline empties, bin counter returns to bin 0, delay
// line clears, trackers rearm to their extreme values.
module spectrum_fir_smoother_minmax import sfsm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] bin_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] smoothed_value,
	output logic [NUM_W-1:0]         bin_number,
	output logic                     frame_done,
	output logic signed [DATA_W-1:0] upper_min,
	output logic signed [DATA_W-1:0] upper_max
);

	logic                    acc_valid, acc_ready;
	logic signed [ACC_W-1:0] acc;
	sb_t                     acc_sb;

	sfsm_fir u_fir (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.bin_value (bin_value),
		.acc_valid (acc_valid),
		.acc_ready (acc_ready),
		.acc       (acc),
		.acc_sb    (acc_sb)
	);

	sfsm_track u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.acc_valid      (acc_valid),
		.acc_ready      (acc_ready),
		.acc            (acc),
		.acc_sb         (acc_sb),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.smoothed_value (smoothed_value),
		.bin_number     (bin_number),
		.frame_done     (frame_done),
		.upper_min      (upper_min),
		.upper_max      (upper_max)
	);

endmodule

// ===== test/smoothing_checker.sv =====
`timescale 1ns / 1ps
module smoothing_checker import sfsm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic signed [DATA_W-1:0] bin_value,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic signed [DATA_W-1:0] smoothed_value,
	input  logic [NUM_W-1:0]         bin_number,
	input  logic                     frame_done,
	input  logic signed [DATA_W-1:0] upper_min,
	input  logic signed [DATA_W-1:0] upper_max,
	output int                       mismatch_count,
	output int                       outstanding,
	output int                       bins_checked,
	output int                       frames_seen
);

	localparam int TAP_HALF [11] = '{
		2, 62, 387, 1395, 3697, 7859, 14025, 21574, 29070, 34645, 36712
	};
	localparam int     TAP_COUNT     = 21;
	localparam int     HIST_DEPTH    = 20;
	localparam int     RAW_PASS_LAST = 21;
	localparam int     HALF_START    = FRAME_LENGTH - FRAME_LENGTH / 2;
	localparam longint SAT_HI        = 64'sd8388607;
	localparam longint SAT_LO        = -64'sd8388608;
	localparam logic signed [DATA_W-1:0] TOP_VALUE    = 24'sh7FFFFF;
	localparam logic signed [DATA_W-1:0] BOTTOM_VALUE = 24'sh800000;

	typedef struct packed {
		logic signed [DATA_W-1:0] smoothed;
		logic [NUM_W-1:0]         num;
		logic                     done;
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
	} bin_result_t;

	logic signed [DATA_W-1:0] raw_hist [HIST_DEPTH];
	int unsigned              frame_pos;
	logic signed [DATA_W-1:0] low_mark;
	logic signed [DATA_W-1:0] high_mark;
	bin_result_t              predicted_bins [$];
	bin_result_t              want;

	function automatic bin_result_t filter_bin(input logic signed [DATA_W-1:0] x);
		bin_result_t              r;
		logic signed [DATA_W-1:0] y;
		longint                   acc;
		int                       tap;
		int                       k;
		r = '0;
		if (frame_pos > RAW_PASS_LAST) begin
			acc = longint'(x) * TAP_HALF[0];
			for (k = 1; k < TAP_COUNT; k++) begin
				tap = (k <= 10) ? TAP_HALF[k] : TAP_HALF[TAP_COUNT - 1 - k];
				acc += longint'(raw_hist[k - 1]) * tap;
			end
			acc = (acc + 64'sd131072) >>> 18;
			if (acc > SAT_HI) acc = SAT_HI;
			if (acc < SAT_LO) acc = SAT_LO;
			y = acc[DATA_W-1:0];
		end else begin
			y = x;
		end
		for (k = HIST_DEPTH - 1; k > 0; k--)
			raw_hist[k] = raw_hist[k - 1];
		raw_hist[0] = x;
		if (frame_pos >= HALF_START) begin
			if (y < low_mark) low_mark = y;
			if (y > high_mark) high_mark = y;
		end
		r.smoothed = y;
		r.num      = frame_pos[NUM_W-1:0];
		r.done     = (frame_pos >= FRAME_LENGTH - 1);
		if (r.done) begin
			r.lo      = low_mark;
			r.hi      = high_mark;
			low_mark  = TOP_VALUE;
			high_mark = BOTTOM_VALUE;
			frame_pos = 0;
		end else begin
			frame_pos++;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (raw_hist[k]) raw_hist[k] = '0;
			frame_pos      = 0;
			low_mark       = TOP_VALUE;
			high_mark      = BOTTOM_VALUE;
			predicted_bins.delete();
			mismatch_count = 0;
			outstanding    = 0;
			bins_checked   = 0;
			frames_seen    = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_bins.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result with nothing pending: bin %0d value %0d",
							$time, bin_number, smoothed_value);
				end else begin
					want = predicted_bins.pop_front();
					bins_checked++;
					if (want.done) frames_seen++;
					if (smoothed_value !== want.smoothed || bin_number !== want.num ||
					    frame_done !== want.done || upper_min !== want.lo ||
					    upper_max !== want.hi) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("%0t: bin %0d expected value %0d done %0b min %0d max %0d",
								$time, want.num, $signed(want.smoothed), want.done,
								$signed(want.lo), $signed(want.hi));
							$display("%0t: bin %0d got      value %0d done %0b min %0d max %0d",
								$time, bin_number, smoothed_value, frame_done,
								upper_min, upper_max);
						end
					end
				end
			end
			if (in_valid && in_ready)
				predicted_bins.insert(predicted_bins.size(), filter_bin(bin_value));
			outstanding = predicted_bins.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import sfsm_pkg::*;

	localparam int DIRECTED_COUNT = 25;
	localparam int BIN_TOTAL      = 1150;
	localparam int STEADY_TAIL    = 300;
	localparam int SQUEEZE_AT     = 400;
	localparam int SQUEEZE_CYCLES = 90;
	localparam int STALL_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 20;

	localparam logic [DATA_W-1:0] DIRECTED_BINS [DIRECTED_COUNT] = '{
		24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001,
		24'hFFFFFE, 24'h555555, 24'hAAAAAA, 24'h7FFFFE, 24'h800001,
		24'h000100, 24'hFFFF00, 24'h123456, 24'hEDCBA9, 24'h0F0F0F,
		24'hF0F0F0, 24'h400000, 24'hC00000, 24'h7FFFFF, 24'h7FFFFF,
		24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h000000
	};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [DATA_W-1:0] bin_value;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [DATA_W-1:0] smoothed_value;
	logic [NUM_W-1:0]         bin_number;
	logic                     frame_done;
	logic signed [DATA_W-1:0] upper_min;
	logic signed [DATA_W-1:0] upper_max;

	int mismatch_count;
	int outstanding;
	int bins_checked;
	int frames_seen;

	int sent_count = 0;
	int stall_cycles;
	int i;
	int seg_kind = 0;
	int seg_left = 0;
	int seg_level = 0;
	bit seg_flip = 1'b0;
	bit steady_tail = 1'b0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit squeezed = 1'b0;

	spectrum_fir_smoother_minmax uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.bin_value      (bin_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.smoothed_value (smoothed_value),
		.bin_number     (bin_number),
		.frame_done     (frame_done),
		.upper_min      (upper_min),
		.upper_max      (upper_max)
	);

	smoothing_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.bin_value      (bin_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.smoothed_value (smoothed_value),
		.bin_number     (bin_number),
		.frame_done     (frame_done),
		.upper_min      (upper_min),
		.upper_max      (upper_max),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding),
		.bins_checked   (bins_checked),
		.frames_seen    (frames_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// segments: full-range noise, dB-like level with jitter, constant level (max, min, 0 or -1),
	// max/min alternation, flat level with rare spikes
	function automatic logic [DATA_W-1:0] next_random_bin();
		int v;
		if (seg_left == 0) begin
			seg_kind = $urandom_range(0, 4);
			seg_left = $urandom_range(8, 60);
			case ($urandom_range(0, 3))
				0: seg_level = 8388607;
				1: seg_level = -8388608;
				2: seg_level = 0;
				default: seg_level = -1;
			endcase
			if (seg_kind == 1 || seg_kind == 4)
				seg_level = int'($urandom_range(0, 8388607)) - 6291456;
		end
		seg_left--;
		case (seg_kind)
			0: v = $urandom;
			1: v = seg_level + int'($urandom_range(0, 8191)) - 4096;
			2: v = seg_level;
			3: begin
				seg_flip = !seg_flip;
				v = seg_flip ? 8388607 : -8388608;
			end
			default: v = ($urandom_range(0, 15) == 0) ? $urandom : seg_level;
		endcase
		return v[DATA_W-1:0];
	endfunction

	task automatic offer_bin(input logic [DATA_W-1:0] value);
		@(negedge clk);
		if ($urandom_range(0, 149) == 0) tx_quiet = !tx_quiet;
		if (!steady_tail && !tx_quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		bin_value <= value;
		do @(posedge clk); while (!in_ready);
		sent_count++;
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		bin_value <= '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (i = 0; i < BIN_TOTAL; i++) begin
			steady_tail = (i >= BIN_TOTAL - STEADY_TAIL);
			offer_bin(i < DIRECTED_COUNT ? DIRECTED_BINS[i] : next_random_bin());
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d bins (%0d directed), %0d results compared, %0d frame ends",
			sent_count, DIRECTED_COUNT, bins_checked, frames_seen);
		$display("output side held off once for %0d cycles; idle bursts of 1..17 cycles",
			SQUEEZE_CYCLES);
		if (mismatch_count == 0 && outstanding == 0)
			$display("spectrum_fir_smoother_minmax: match");
		else
			$display("spectrum_fir_smoother_minmax: mismatch");
		$finish;
	end

	// sink side; one long hold-off fills the pipeline and stalls the input
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0) rx_quiet = !rx_quiet;
			if (!squeezed && sent_count >= SQUEEZE_AT) begin
				squeezed = 1'b1;
				out_ready <= 1'b0;
				repeat (SQUEEZE_CYCLES - 1) @(negedge clk);
			end else if (!steady_tail && !rx_quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("spectrum_fir_smoother_minmax: mismatch");
		$finish;
	end

endmodule
